### hdl/wtc_pkg.sv
`timescale 1ns / 1ps

package wtc_pkg;

   // Splitter set after reset: ; : { } [ ] ( ) , . @ = ! - + * % ^ & | backslash
   localparam logic [63:0] SPLIT_LOW_RESET  = 64'd3170674196552351744;
   localparam logic [63:0] SPLIT_HIGH_RESET = 64'd4035225268137230337;

   localparam int unsigned CSR_COUNT = 2;
   localparam int unsigned CSR_IDX_W = $clog2(CSR_COUNT);
   localparam logic [CSR_IDX_W-1:0] CSR_SPLIT_LOW  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPLIT_HIGH = 1'd1;

   localparam logic [2:0] EV_BYTE     = 3'd1;
   localparam logic [2:0] EV_WEND     = 3'd2;
   localparam logic [2:0] EV_SPLIT    = 3'd3;
   localparam logic [2:0] EV_END      = 3'd4;
   localparam logic [2:0] EV_UNCLOSED = 3'd5;

   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_SPACE = 8'h20;

   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_LINE   = 2'd1,
      MODE_BLOCK  = 2'd2,
      MODE_STAR   = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type    mode;
      logic        inside_word;
      logic        slash_pending;
      logic [31:0] line_count;
   } state_type;

   localparam state_type STATE_RESET = '{
      mode:          MODE_NORMAL,
      inside_word:   1'b0,
      slash_pending: 1'b0,
      line_count:    32'd1
   };

   typedef struct packed {
      logic        last_result;
      logic [31:0] line_number;
      logic [7:0]  token_byte;
      logic [2:0]  event_res;
   } result_type;

endpackage

### hdl/word_tokenizer_with_comments_unit.sv
`timescale 1ns / 1ps

// Word tokenizer with C-style comment removal. Each req transaction carries one text byte
// (or an end-of-stream marker on req_tlast) and yields zero, one or two rsp transactions:
// word bytes, word ends, one-character splitter tokens, end of stream, or an unclosed
// block comment error. A slash is held until the next byte shows whether it opens a
// comment, so that next byte may produce two results. With rsp_tready held high the block
// takes one byte per clock as long as each byte yields at most one result; a byte that
// yields two results sends both in turn on the single result port. req_tready drops while
// the results already queued plus those of the held byte would overflow the two-entry
// result queue; the queue count is taken as registered, without the result leaving in
// the same cycle, so in such a stream a two-result byte stalls the input. A byte
// is registered, and its results are queued, before they reach rsp. The splitter set is
// written through csr_ (index 0: bytes 0-63, index 1: bytes 64-127) while the stream is
// idle, a rule for the user that the block does not enforce. End of stream returns the
// scanner, including the line counter, to its reset state but keeps the splitter set.

module word_tokenizer_with_comments_unit (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic        req_tlast,   // end_of_input
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [2:0] event_res, [10:3] token_byte,
                                    // [42:11] line_number, [47:43] zero
   output logic        rsp_tlast,   // last_result
   // configuration
   input  logic        csr_we,
   input  logic [wtc_pkg::CSR_IDX_W-1:0] csr_addr,
   input  logic [63:0] csr_wdata
);
   import wtc_pkg::*;

   // splitter set registers
   logic [63:0] split_low_ff;
   logic [63:0] split_high_ff;

   // input register
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_end_ff;

   // scanner state
   state_type   state_ff, state_in;

   // step results
   state_type   step_state;
   logic [1:0]  step_count;
   result_type  step_res0;
   result_type  step_res1;

   // result queue
   result_type  head;
   logic [1:0]  queue_count;
   logic        pop;
   logic        advance;
   logic        req_take;
   logic [2:0]  fill;

   // the step may retire only if the queue, as registered, can take all of its results
   assign fill      = {1'b0, queue_count} + {1'b0, step_count};
   assign advance   = in_valid_ff && (fill <= 3'd2);
   assign req_tready = !in_valid_ff || advance;
   assign req_take  = req_tvalid && req_tready;
   assign pop       = rsp_tvalid && rsp_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (advance) in_valid_in = 1'b0;
      if (req_take) in_valid_in = 1'b1;
      state_in = advance ? step_state : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         state_ff      <= STATE_RESET;
         split_low_ff  <= SPLIT_LOW_RESET;
         split_high_ff <= SPLIT_HIGH_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
         if (csr_we) begin
            unique case (csr_addr)
               CSR_SPLIT_LOW:  split_low_ff  <= csr_wdata;
               CSR_SPLIT_HIGH: split_high_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
      if (req_take) begin
         in_byte_ff <= req_tdata;
         in_end_ff  <= req_tlast;
      end
   end

   wtc_step u_step (
      .state        (state_ff),
      .text_byte    (in_byte_ff),
      .end_of_input (in_end_ff),
      .splitter_set ({split_high_ff, split_low_ff}),
      .state_next   (step_state),
      .res_count    (step_count),
      .res0         (step_res0),
      .res1         (step_res1)
   );

   wtc_rsp_buffer u_rsp_buffer (
      .clock      (clock),
      .reset      (reset),
      .push_count (advance ? step_count : 2'd0),
      .push0      (step_res0),
      .push1      (step_res1),
      .pop        (pop),
      .head       (head),
      .count      (queue_count)
   );

   assign rsp_tvalid = (queue_count != 2'd0);
   assign rsp_tdata  = {5'd0, head.line_number, head.token_byte, head.event_res};
   assign rsp_tlast  = head.last_result;

endmodule

### hdl/wtc_step.sv
`timescale 1ns / 1ps

module wtc_step (
   input  wtc_pkg::state_type  state,
   input  logic [7:0]          text_byte,
   input  logic                end_of_input,
   input  logic [127:0]        splitter_set,
   output wtc_pkg::state_type  state_next,
   output logic [1:0]          res_count,
   output wtc_pkg::result_type res0,
   output wtc_pkg::result_type res1
);
   import wtc_pkg::*;

   logic       is_space;
   logic       is_split;
   logic       word;
   logic       done;
   logic [1:0] cnt;
   result_type r;

   assign is_space = (text_byte == CH_NL) || (text_byte == CH_SPACE) ||
                     (text_byte == CH_CR) || (text_byte == CH_TAB);
   assign is_split = !text_byte[7] && splitter_set[text_byte[6:0]];

   always_comb begin
      state_next = state;
      cnt        = 2'd0;
      res0       = '0;
      res1       = '0;
      r          = '0;
      word       = state.inside_word;
      done       = 1'b0;
      r.line_number = state.line_count;

      if (end_of_input) begin
         if (state.mode == MODE_BLOCK || state.mode == MODE_STAR) begin
            r.event_res = EV_UNCLOSED;
            res0 = r;
            cnt  = 2'd1;
         end else begin
            if (state.mode == MODE_NORMAL && state.slash_pending) begin
               r.event_res  = EV_BYTE;
               r.token_byte = CH_SLASH;
               res0 = r;
               cnt  = 2'd1;
            end
            r.event_res  = EV_END;
            r.token_byte = 8'd0;
            if (cnt == 2'd0) res0 = r;
            else res1 = r;
            cnt = cnt + 2'd1;
         end
         state_next = STATE_RESET;
      end else begin
         unique case (state.mode)
            MODE_LINE: begin
               if (text_byte == CH_NL) begin
                  state_next.line_count = state.line_count + 32'd1;
                  state_next.mode       = MODE_NORMAL;
               end
            end
            MODE_BLOCK: begin
               if (text_byte == CH_NL) begin
                  state_next.line_count = state.line_count + 32'd1;
               end else if (text_byte == CH_STAR) begin
                  state_next.mode = MODE_STAR;
               end
            end
            MODE_STAR: begin
               if (text_byte == CH_NL) begin
                  state_next.line_count = state.line_count + 32'd1;
                  state_next.mode       = MODE_BLOCK;
               end else if (text_byte == CH_SLASH) begin
                  state_next.mode = MODE_NORMAL;
               end else if (text_byte != CH_STAR) begin
                  state_next.mode = MODE_BLOCK;
               end
            end
            default: begin
               state_next.mode          = MODE_NORMAL;
               state_next.slash_pending = 1'b0;
               if (state.slash_pending) begin
                  if (text_byte == CH_SLASH || text_byte == CH_STAR) begin
                     // comment opener: close any word and drop into comment mode
                     if (state.inside_word) begin
                        r.event_res = EV_WEND;
                        res0 = r;
                        cnt  = 2'd1;
                     end
                     word = 1'b0;
                     state_next.mode = (text_byte == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
                     done = 1'b1;
                  end else begin
                     // the held slash was an ordinary word byte
                     r.event_res  = EV_BYTE;
                     r.token_byte = CH_SLASH;
                     res0 = r;
                     cnt  = 2'd1;
                     word = 1'b1;
                  end
               end
               if (!done) begin
                  r.token_byte = 8'd0;
                  if (is_space) begin
                     if (text_byte == CH_NL) begin
                        state_next.line_count = state.line_count + 32'd1;
                     end
                     if (word) begin
                        r.event_res = EV_WEND;
                        if (cnt == 2'd0) res0 = r;
                        else res1 = r;
                        cnt = cnt + 2'd1;
                     end
                     word = 1'b0;
                  end else if (text_byte == CH_SLASH) begin
                     state_next.slash_pending = 1'b1;
                  end else begin
                     r.event_res  = is_split ? EV_SPLIT : EV_BYTE;
                     r.token_byte = text_byte;
                     if (cnt == 2'd0) res0 = r;
                     else res1 = r;
                     cnt  = cnt + 2'd1;
                     word = !is_split;
                  end
               end
               state_next.inside_word = word;
            end
         endcase
      end

      if (cnt == 2'd1) res0.last_result = 1'b1;
      if (cnt == 2'd2) res1.last_result = 1'b1;
   end

   assign res_count = cnt;

endmodule

### hdl/wtc_rsp_buffer.sv
`timescale 1ns / 1ps

module wtc_rsp_buffer (
   input  logic                clock,
   input  logic                reset,
   input  logic [1:0]          push_count,
   input  wtc_pkg::result_type push0,
   input  wtc_pkg::result_type push1,
   input  logic                pop,
   output wtc_pkg::result_type head,
   output logic [1:0]          count
);
   import wtc_pkg::*;

   // two-entry queue: slot0 is the head, entries shift down on pop
   result_type slot0_ff, slot0_in;
   result_type slot1_ff, slot1_in;
   logic [1:0] count_ff, count_in;
   logic [1:0] rem_count;
   result_type rem0;

   always_comb begin
      rem_count = count_ff - {1'b0, pop};
      rem0      = pop ? slot1_ff : slot0_ff;
      slot0_in  = (rem_count != 2'd0) ? rem0 : push0;
      if (rem_count == 2'd2) slot1_in = slot1_ff;
      else if (rem_count == 2'd1) slot1_in = push0;
      else slot1_in = push1;
      count_in = rem_count + push_count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign head  = slot0_ff;
   assign count = count_ff;

endmodule
